[design/dpvl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvl_pkg: shared types and constants of the dual PI voltage loop
// Op codes, register indexes, configuration bundle and the symmetric clamp.
// ----------------------------------------------------------------------------
package dpvl_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int CHANNELS_DEF = 2;

    localparam int OFFS_W     = 10;
    localparam int GAIN_W     = 10;
    localparam int TGT_W      = 11;
    localparam int REF_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int INTEG_W    = 17;
    localparam int ERR_W      = 18;
    localparam int DUTY_W     = 12;
    localparam int CLAMP_IN_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LIMIT      = 55200;
    localparam int FEED_EXTRA = 2;
    localparam int DUTY_SHIFT = 5;
    localparam int DUTY_MAX   = LIMIT / (2 ** DUTY_SHIFT);

    localparam logic [OFFS_W-1:0]     OFFSET_RST = OFFS_W'(512);
    localparam logic [GAIN_W-1:0]     PGAIN_RST  = GAIN_W'(32);
    localparam logic [GAIN_W-1:0]     IGAIN_RST  = GAIN_W'(1);
    localparam logic [TGT_W-1:0]      TARGET_RST = TGT_W'(1000);
    localparam logic [REF_W-1:0]      REF_RST    = REF_W'(-1725);
    localparam logic [PERIOD_W-1:0]   PERIOD_RST = PERIOD_W'(1000);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET      = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_TARGET_R    = 3'd3,
        REG_TARGET_Y    = 3'd4,
        REG_START_REF   = 3'd5,
        REG_RAMP_PERIOD = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [OFFS_W-1:0]       offset_code;
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       integ_gain;
        logic [TGT_W-1:0]        target_ref_r;
        logic [TGT_W-1:0]        target_ref_y;
        logic signed [REF_W-1:0] start_ref;
        logic [PERIOD_W-1:0]     ramp_period;
    } cfg_t;

    // saturate to +-LIMIT
    function automatic logic signed [INTEG_W-1:0] clamp_lim(
        input logic signed [CLAMP_IN_W-1:0] x
    );
        logic signed [INTEG_W-1:0] r;
        if (x >= CLAMP_IN_W'(LIMIT)) begin
            r = INTEG_W'(LIMIT);
        end else if (x <= -CLAMP_IN_W'(LIMIT)) begin
            r = -INTEG_W'(LIMIT);
        end else begin
            r = INTEG_W'(x);
        end
        return r;
    endfunction

endpackage

[design/dpvl_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvl_cfg: configuration register file
// Seven registers written through an index/data channel; unknown indexes drop.
// ----------------------------------------------------------------------------
module dpvl_cfg
    import dpvl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OFFSET:      cfg_next.offset_code  = cfg_data[OFFS_W-1:0];
                REG_PROP_GAIN:   cfg_next.prop_gain    = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_next.integ_gain   = cfg_data[GAIN_W-1:0];
                REG_TARGET_R:    cfg_next.target_ref_r = cfg_data[TGT_W-1:0];
                REG_TARGET_Y:    cfg_next.target_ref_y = cfg_data[TGT_W-1:0];
                REG_START_REF:   cfg_next.start_ref    = $signed(cfg_data[REF_W-1:0]);
                REG_RAMP_PERIOD: cfg_next.ramp_period  = cfg_data[PERIOD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_code  <= OFFSET_RST;
            cfg_reg.prop_gain    <= PGAIN_RST;
            cfg_reg.integ_gain   <= IGAIN_RST;
            cfg_reg.target_ref_r <= TARGET_RST;
            cfg_reg.target_ref_y <= TARGET_RST;
            cfg_reg.start_ref    <= $signed(REF_RST);
            cfg_reg.ramp_period  <= PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/dpvl_err.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvl_err: loop state and error stage
// Holds references, integrals and the ramp counter; forms error and integral.
// ----------------------------------------------------------------------------
module dpvl_err
    import dpvl_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    input  op_t                        in_op,
    input  logic                       in_channel,
    input  logic [ADC_BITS-1:0]        in_sample,
    output logic                       in_take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_channel,
    output logic signed [ERR_W-1:0]    out_err,
    output logic signed [INTEG_W-1:0]  out_integ
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FB_W = ADC_BITS + 4;

    logic signed [REF_W-1:0]   ref_reg   [CHANNELS];
    logic signed [REF_W-1:0]   ref_next  [CHANNELS];
    logic signed [INTEG_W-1:0] integ_reg [CHANNELS];
    logic signed [INTEG_W-1:0] integ_next[CHANNELS];
    logic [PERIOD_W-1:0]       tick_reg;
    logic [PERIOD_W-1:0]       tick_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      ch_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] acc_reg;

    logic [CH_W-1:0]           ch_idx;
    logic                      ch_ok;
    logic                      is_sample;
    logic                      stage_ready;
    logic [FB_W-1:0]           diff;
    logic [FB_W-1:0]           fb;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] acc;
    logic [PERIOD_W-1:0]       tick_inc;
    logic                      ramp_step;

    assign ch_idx      = CH_W'(in_channel);
    assign ch_ok       = ({31'd0, in_channel} < 32'(CHANNELS));
    assign is_sample   = (in_op == OP_SAMPLE) && ch_ok;
    assign stage_ready = !valid_reg || out_ready;
    assign in_take     = in_valid && (!is_sample || stage_ready);

    // feedback: (code - offset - 2) * 2, floored at zero
    assign diff = FB_W'(in_sample) - FB_W'(cfg.offset_code) - FB_W'(FEED_EXTRA);
    assign fb   = (diff[FB_W-1] || (diff == '0)) ? '0 : {diff[FB_W-2:0], 1'b0};
    assign err  = ERR_W'(ref_reg[ch_idx]) - $signed(ERR_W'(fb));
    assign acc  = clamp_lim(CLAMP_IN_W'(integ_reg[ch_idx]) + CLAMP_IN_W'(err));

    assign tick_inc  = tick_reg + PERIOD_W'(1);
    assign ramp_step = (tick_inc >= cfg.ramp_period);

    always_comb begin
        logic signed [REF_W:0] ref_inc;
        logic signed [REF_W:0] tgt;
        tick_next = tick_reg;
        for (int k = 0; k < CHANNELS; k++) begin
            ref_next[k]   = ref_reg[k];
            integ_next[k] = integ_reg[k];
        end
        ref_inc = '0;
        tgt     = '0;
        if (in_take) begin
            unique case (in_op)
                OP_TICK: begin
                    tick_next = ramp_step ? '0 : tick_inc;
                    if (ramp_step) begin
                        for (int k = 0; k < CHANNELS; k++) begin
                            ref_inc = (REF_W + 1)'(ref_reg[k]) + (REF_W + 1)'(1);
                            tgt = $signed((REF_W + 1)'(
                                (k == 0) ? cfg.target_ref_r : cfg.target_ref_y));
                            ref_next[k] = (ref_inc >= tgt) ? REF_W'(tgt) : REF_W'(ref_inc);
                        end
                    end
                end
                OP_RESTART: begin
                    for (int k = 0; k < CHANNELS; k++) begin
                        ref_next[k]   = cfg.start_ref;
                        integ_next[k] = '0;
                    end
                end
                OP_SAMPLE: begin
                    if (ch_ok) begin
                        integ_next[ch_idx] = acc;
                    end
                end
                default: tick_next = tick_reg;
            endcase
        end
    end

    assign valid_next = stage_ready ? (in_take && is_sample) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tick_reg  <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                ref_reg[k]   <= $signed(REF_RST);
                integ_reg[k] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            tick_reg  <= tick_next;
            for (int k = 0; k < CHANNELS; k++) begin
                ref_reg[k]   <= ref_next[k];
                integ_reg[k] <= integ_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready) begin
            ch_reg  <= in_channel;
            err_reg <= err;
            acc_reg <= acc;
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = ch_reg;
    assign out_err     = err_reg;
    assign out_integ   = acc_reg;

endmodule

[design/dpvl_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvl_mul: gain stage
// Proportional and integral products, each clamped, registered.
// ----------------------------------------------------------------------------
module dpvl_mul
    import dpvl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_channel,
    input  logic signed [ERR_W-1:0]    in_err,
    input  logic signed [INTEG_W-1:0]  in_integ,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_channel,
    output logic signed [INTEG_W-1:0]  out_p,
    output logic signed [INTEG_W-1:0]  out_i
);

    logic                            valid_reg;
    logic                            valid_next;
    logic                            ch_reg;
    logic signed [INTEG_W-1:0]       p_reg;
    logic signed [INTEG_W-1:0]       i_reg;
    logic signed [ERR_W+GAIN_W:0]    prod_p;
    logic signed [INTEG_W+GAIN_W:0]  prod_i;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign prod_p = in_err * $signed({1'b0, cfg.prop_gain});
    assign prod_i = in_integ * $signed({1'b0, cfg.integ_gain});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            ch_reg <= in_channel;
            p_reg  <= clamp_lim(CLAMP_IN_W'(prod_p));
            i_reg  <= clamp_lim(CLAMP_IN_W'(prod_i));
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = ch_reg;
    assign out_p       = p_reg;
    assign out_i       = i_reg;

endmodule

[design/dpvl_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvl_out: output stage
// Sum of P and I, clamp, floor shift to duty; result register.
// ----------------------------------------------------------------------------
module dpvl_out
    import dpvl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_channel,
    input  logic signed [INTEG_W-1:0]  in_p,
    input  logic signed [INTEG_W-1:0]  in_i,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_channel,
    output logic signed [DUTY_W-1:0]   out_duty
);

    logic                        valid_reg;
    logic                        valid_next;
    logic                        ch_reg;
    logic signed [DUTY_W-1:0]    duty_reg;
    logic signed [INTEG_W:0]     sum;
    logic signed [INTEG_W-1:0]   sum_lim;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign sum     = (INTEG_W + 1)'(in_p) + (INTEG_W + 1)'(in_i);
    assign sum_lim = clamp_lim(CLAMP_IN_W'(sum));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // arithmetic shift floors toward minus infinity
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            ch_reg   <= in_channel;
            duty_reg <= DUTY_W'(sum_lim >>> DUTY_SHIFT);
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = ch_reg;
    assign out_duty    = duty_reg;

endmodule

[design/dual_pi_voltage_loop_soft_start.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pi_voltage_loop_soft_start: two-channel PI voltage loop with soft start
// Tick beats ramp the references toward their targets, sample beats run the
// PI update of one channel and return a duty beat, restart beats reload the
// references and clear the integrators.
// ----------------------------------------------------------------------------
//  port group | dir | beat contents
//  s_*        | in  | tuser: op; tdata: channel, sample
//  m_*        | out | tdata: out_channel, duty
//  cfg_*      | in  | cfg_index selects register, cfg_data carries its value
//
//  Throughput: one beat per cycle on s_* with m_tready held high.
//  A sample beat passes the input register, the error/state stage, the gain
//  multipliers and the sum/output register before its duty beat goes out.
//  Tick and restart beats update state on the edge after acceptance, no output.
//  Each stage holds on back-pressure; bubbles ahead of a stall still fill.
//  aresetn is synchronous, active low; references reset to -1725.
// ----------------------------------------------------------------------------
module dual_pi_voltage_loop_soft_start
    import dpvl_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int CHANNELS = CHANNELS_DEF,
    localparam int S_DATA_W = ((1 + ADC_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((1 + DUTY_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_tuser,   // [1:0] op
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] channel, [ADC_BITS:1] sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [0] out_channel, [12:1] duty
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    // input register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    op_t                   in_op_reg;
    logic                  in_ch_reg;
    logic [ADC_BITS-1:0]   in_sample_reg;
    logic                  in_take;

    // stage hand-offs
    logic                       err_valid;
    logic                       err_ready;
    logic                       err_ch;
    logic signed [ERR_W-1:0]    err_val;
    logic signed [INTEG_W-1:0]  err_integ;
    logic                       mul_valid;
    logic                       mul_ready;
    logic                       mul_ch;
    logic signed [INTEG_W-1:0]  mul_p;
    logic signed [INTEG_W-1:0]  mul_i;
    logic                       m_ch;
    logic signed [DUTY_W-1:0]   m_duty;

    dpvl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register frees as soon as the state stage takes the beat
    assign s_tready      = !in_valid_reg || in_take;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_op_reg     <= op_t'(s_tuser);
            in_ch_reg     <= s_tdata[0];
            in_sample_reg <= s_tdata[ADC_BITS:1];
        end
    end

    dpvl_err #(
        .ADC_BITS (ADC_BITS),
        .CHANNELS (CHANNELS)
    ) u_err (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (in_valid_reg),
        .in_op       (in_op_reg),
        .in_channel  (in_ch_reg),
        .in_sample   (in_sample_reg),
        .in_take     (in_take),
        .out_valid   (err_valid),
        .out_ready   (err_ready),
        .out_channel (err_ch),
        .out_err     (err_val),
        .out_integ   (err_integ)
    );

    dpvl_mul u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (err_valid),
        .in_ready    (err_ready),
        .in_channel  (err_ch),
        .in_err      (err_val),
        .in_integ    (err_integ),
        .out_valid   (mul_valid),
        .out_ready   (mul_ready),
        .out_channel (mul_ch),
        .out_p       (mul_p),
        .out_i       (mul_i)
    );

    dpvl_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mul_valid),
        .in_ready    (mul_ready),
        .in_channel  (mul_ch),
        .in_p        (mul_p),
        .in_i        (mul_i),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (m_ch),
        .out_duty    (m_duty)
    );

    assign m_tdata = {(M_DATA_W - 1 - DUTY_W)'(0), m_duty, m_ch};

`ifndef NO_ASSERTIONS
    // a new duty beat only appears after the gain stage held a sample
    a_out_from_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(mul_valid))
        else $error("duty beat without a preceding gain stage entry");

    // the error stage only fills from a sample beat in the input register
    a_mul_from_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(err_valid) |-> $past(in_valid_reg && (in_op_reg == OP_SAMPLE)))
        else $error("error stage filled by a non-sample beat");

    // clamped sum keeps the duty inside the shifted limit
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_duty >= -DUTY_MAX) && (m_duty <= DUTY_MAX)))
        else $error("duty outside clamp range");
`endif

endmodule

[verif/tb_dual_pi_voltage_loop_soft_start.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_pi_voltage_loop_soft_start: self-checking bench for the PI loop
// A queued driver feeds tick, sample, restart and unused-op beats plus register
// writes. An in-bench model of the ramp, the clamped PI update and the duty
// shift predicts each duty beat, and the monitor compares every field in order.
// ----------------------------------------------------------------------------
module tb_dual_pi_voltage_loop_soft_start;
    import dpvl_pkg::*;

    localparam int ADC_W = ADC_BITS_DEF;
    localparam int S_W   = ((1 + ADC_W + 7) / 8) * 8;
    localparam int M_W   = ((1 + DUTY_W + 7) / 8) * 8;

    // op code the block must drop, and a register index with no register
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int SETTLE_CYCLES = 8;      // hold-off after the last duty beat
    localparam int DRAIN_CYCLES  = 20;
    localparam int CALM_TAIL     = 150;    // last plan steps run without idling
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_WRITE,
        STEP_SETTLE
    } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [1:0]             op;
        logic                   chan;
        logic [ADC_W-1:0]       code;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
    } plan_step_t;

    typedef struct {
        logic                     chan;
        logic signed [DUTY_W-1:0] duty;
    } duty_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser   = '0;   // [1:0] op
    logic [S_W-1:0]        s_tdata   = '0;   // [0] channel, [ADC_W:1] sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;          // [0] out_channel, [12:1] duty
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    plan_step_t stim_plan[$];
    duty_beat_t duty_due[$];

    // loop model state
    cfg_t   loop_cfg;
    int     soft_ref[2];
    longint integ_acc[2];
    int     tick_cnt;

    int  fails       = 0;
    int  cycle_cnt   = 0;
    int  gap_left    = 0;
    int  hold_left   = 0;
    int  stall_left  = 0;
    bit  quiet_tail  = 1'b0;

    dual_pi_voltage_loop_soft_start i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Loop model
    // ------------------------------------------------------------------
    function automatic longint sat_limit(input longint x);
        if (x >= LIMIT) return LIMIT;
        if (x <= -LIMIT) return -LIMIT;
        return x;
    endfunction

    // soft-start ramp: one step per period, each reference capped at its target
    function automatic void ramp_tick();
        int r;
        int tgt;
        tick_cnt = (tick_cnt + 1) & 16'hFFFF;
        if (tick_cnt >= int'(loop_cfg.ramp_period)) begin
            for (int k = 0; k < 2; k++) begin
                tgt = (k == 0) ? int'(loop_cfg.target_ref_r) : int'(loop_cfg.target_ref_y);
                r   = soft_ref[k] + 1;
                if (r >= tgt) r = tgt;   // also pulls a reference above target down
                soft_ref[k] = r;
            end
            tick_cnt = 0;
        end
    endfunction

    function automatic duty_beat_t pi_duty_update(input logic ch, input logic [ADC_W-1:0] code);
        duty_beat_t res;
        longint fb;
        longint err;
        longint p_term;
        longint i_term;
        longint sum;
        fb = (longint'(code) - (longint'(loop_cfg.offset_code) + FEED_EXTRA)) * 2;
        if (fb < 0) fb = 0;
        err    = longint'(soft_ref[ch]) - fb;
        p_term = sat_limit(err * longint'(loop_cfg.prop_gain));
        integ_acc[ch] = sat_limit(integ_acc[ch] + err);
        i_term = sat_limit(integ_acc[ch] * longint'(loop_cfg.integ_gain));
        sum    = sat_limit(p_term + i_term);
        res.chan = ch;
        res.duty = DUTY_W'(sum >>> DUTY_SHIFT);   // floor division by 32
        return res;
    endfunction

    function automatic void absorb_beat(input logic [1:0] op, input logic ch,
                                        input logic [ADC_W-1:0] code);
        case (op)
            OP_TICK: begin
                ramp_tick();
            end
            OP_SAMPLE: begin
                duty_due.push_back(pi_duty_update(ch, code));
            end
            OP_RESTART: begin
                // tick counter deliberately left alone
                for (int k = 0; k < 2; k++) begin
                    soft_ref[k]  = int'($signed(loop_cfg.start_ref));
                    integ_acc[k] = 0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_OFFSET:      loop_cfg.offset_code  = val[OFFS_W-1:0];
            REG_PROP_GAIN:   loop_cfg.prop_gain    = val[GAIN_W-1:0];
            REG_INTEG_GAIN:  loop_cfg.integ_gain   = val[GAIN_W-1:0];
            REG_TARGET_R:    loop_cfg.target_ref_r = val[TGT_W-1:0];
            REG_TARGET_Y:    loop_cfg.target_ref_y = val[TGT_W-1:0];
            REG_START_REF:   loop_cfg.start_ref    = val;
            REG_RAMP_PERIOD: loop_cfg.ramp_period  = val;
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------
    task automatic add_beat(input logic [1:0] op, input logic ch, input int code);
        plan_step_t st;
        st.kind  = STEP_BEAT;
        st.op    = op;
        st.chan  = ch;
        st.code  = ADC_W'(code);
        st.idx   = '0;
        st.value = '0;
        stim_plan.push_back(st);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        plan_step_t st;
        st.kind  = STEP_WRITE;
        st.op    = OP_TICK;
        st.chan  = 1'b0;
        st.code  = '0;
        st.idx   = idx;
        st.value = val;
        stim_plan.push_back(st);
    endtask

    task automatic add_settle();
        plan_step_t st;
        st.kind  = STEP_SETTLE;
        st.op    = OP_TICK;
        st.chan  = 1'b0;
        st.code  = '0;
        st.idx   = '0;
        st.value = '0;
        stim_plan.push_back(st);
    endtask

    // narrow registers sometimes get junk above their width; the block keeps low bits
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int v, input int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) << w : '0;
        return CFG_DATA_W'(v) | junk;
    endfunction

    task automatic add_settings(input int offs, input int pg, input int ig, input int tr,
                                input int ty, input int sr, input int per);
        add_settle();
        add_write(REG_OFFSET,      with_junk(offs, OFFS_W));
        add_write(REG_PROP_GAIN,   with_junk(pg, GAIN_W));
        add_write(REG_INTEG_GAIN,  with_junk(ig, GAIN_W));
        add_write(REG_TARGET_R,    with_junk(tr, TGT_W));
        add_write(REG_TARGET_Y,    with_junk(ty, TGT_W));
        add_write(REG_START_REF,   CFG_DATA_W'(sr));
        add_write(REG_RAMP_PERIOD, CFG_DATA_W'(per));
    endtask

    // mostly samples near the offset so the error stays in the linear range
    task automatic add_random_beats(input int n, input int offs);
        int pick;
        int code;
        for (int i = 0; i < n; i++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 55) begin
                if ($urandom_range(0, 9) < 7) begin
                    code = offs + FEED_EXTRA + int'($urandom_range(0, 40)) - 20;
                    if (code < 0) code = 0;
                    if (code > 1023) code = 1023;
                end else begin
                    code = int'($urandom_range(0, 1023));
                end
                add_beat(OP_SAMPLE, 1'($urandom), code);
            end else if (pick < 93) begin
                add_beat(OP_TICK, 1'($urandom), int'($urandom_range(0, 1023)));
            end else if (pick < 96) begin
                add_beat(OP_RESTART, 1'($urandom), int'($urandom_range(0, 1023)));
            end else begin
                add_beat(OP_UNUSED, 1'($urandom), int'($urandom_range(0, 1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: input beats, register writes and settle points from the plan
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        plan_step_t nxt;
        logic nv_s;
        logic nv_c;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left  = 0;
            hold_left = 0;
        end else begin
            nv_s = s_tvalid && !s_tready;
            nv_c = cfg_valid && !cfg_ready;
            if (s_tvalid && s_tready) begin
                absorb_beat(s_tuser, s_tdata[0], s_tdata[ADC_W:1]);
            end
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index, cfg_data);
            end
            if (!nv_s && !nv_c) begin
                if (hold_left > 0) begin
                    // wait for every duty beat, then let tick/restart state settle
                    if (duty_due.size() == 0) hold_left--;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_plan.size() > 0) begin
                    if (stim_plan[0].kind == STEP_BEAT && !quiet_tail &&
                        $urandom_range(0, 3) == 0) begin
                        gap_left = int'($urandom_range(1, 9)) - 1;
                    end else begin
                        nxt = stim_plan.pop_front();
                        case (nxt.kind)
                            STEP_BEAT: begin
                                nv_s = 1'b1;
                                s_tuser <= nxt.op;
                                s_tdata <= S_W'({nxt.code, nxt.chan});
                            end
                            STEP_WRITE: begin
                                nv_c = 1'b1;
                                cfg_index <= nxt.idx;
                                cfg_data  <= nxt.value;
                            end
                            default: begin
                                hold_left = SETTLE_CYCLES;
                            end
                        endcase
                    end
                end
            end
            s_tvalid   <= nv_s;
            cfg_valid  <= nv_c;
            quiet_tail <= (stim_plan.size() < CALM_TAIL);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: duty beats against the oldest prediction, random back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        duty_beat_t got;
        duty_beat_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.chan = m_tdata[0];
                got.duty = m_tdata[DUTY_W:1];
                if (duty_due.size() == 0) begin
                    $error("duty beat with nothing pending: out_channel %0d duty %0d",
                           got.chan, got.duty);
                    fails++;
                end else begin
                    want = duty_due.pop_front();
                    if (got.chan !== want.chan) begin
                        $error("out_channel: expected %0d, got %0d", want.chan, got.chan);
                        fails++;
                    end
                    if (got.duty !== want.duty) begin
                        $error("duty: expected %0d, got %0d", want.duty, got.duty);
                        fails++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                stall_left = int'($urandom_range(1, 9)) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int offs;
        int pg;
        int ig;
        int tr;
        int ty;
        int sr;
        int per;

        loop_cfg = '{offset_code: OFFSET_RST, prop_gain: PGAIN_RST, integ_gain: IGAIN_RST,
                     target_ref_r: TARGET_RST, target_ref_y: TARGET_RST,
                     start_ref: REF_RST, ramp_period: PERIOD_RST};
        for (int k = 0; k < 2; k++) begin
            soft_ref[k]  = int'($signed(REF_RST));
            integ_acc[k] = 0;
        end
        tick_cnt = 0;

        // directed: reset settings, code extremes on both channels, every op
        add_beat(OP_SAMPLE, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b1, 1023);
        add_beat(OP_SAMPLE, 1'b0, 1023);
        add_beat(OP_SAMPLE, 1'b1, 0);
        add_beat(OP_TICK, 1'b1, 1023);
        add_beat(OP_UNUSED, 1'b1, 1023);           // dropped, no state change
        add_beat(OP_SAMPLE, 1'b0, 514);            // code at offset + 2: feedback exactly zero
        add_beat(OP_RESTART, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b1, 600);

        // zero ramp period: every tick steps; full gains saturate
        add_settings(0, 1023, 1023, 5, 2047, 0, 0);
        add_write(REG_UNUSED, 16'hFFFF);           // write to a missing register
        add_beat(OP_RESTART, 1'b1, 0);
        add_beat(OP_TICK, 1'b0, 0);
        add_beat(OP_TICK, 1'b0, 0);
        add_beat(OP_TICK, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b1, 1023);
        add_beat(OP_SAMPLE, 1'b1, 1);

        // target dropped below the running reference: next step snaps to it
        add_settle();
        add_write(REG_TARGET_R, CFG_DATA_W'(0));
        add_beat(OP_TICK, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b0, 0);
        add_beat(OP_SAMPLE, 1'b1, 3);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin
                    offs = 0;    pg = 0;    ig = 0;    tr = 0;
                    ty = 0;      sr = 0;    per = 0;
                end
                1: begin
                    offs = 1023; pg = 1023; ig = 1023; tr = 2047;
                    ty = 2047;   sr = -32768; per = 65535;
                end
                8: begin
                    offs = 512;  pg = 32;   ig = 1;    tr = 30;
                    ty = 1000;   sr = -1725; per = 1;
                end
                default: begin
                    offs = int'($urandom_range(0, 1023));
                    pg   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                                        : int'($urandom_range(0, 48));
                    ig   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                                        : int'($urandom_range(0, 8));
                    tr   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 60))
                                                        : int'($urandom_range(0, 2047));
                    ty   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 60))
                                                        : int'($urandom_range(0, 2047));
                    sr   = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 32768))
                                                        : -int'($urandom_range(0, 80));
                    per  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(7, 300))
                                                        : int'($urandom_range(0, 6));
                end
            endcase
            add_settings(offs, pg, ig, tr, ty, sr, per);
            add_beat(OP_RESTART, 1'($urandom), int'($urandom_range(0, 1023)));
            add_random_beats(200, offs);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_plan.size() != 0 || s_tvalid || cfg_valid || duty_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (duty_due.size() != 0) begin
            $error("%0d predicted duty beats never arrived", duty_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[dual_pi_voltage_loop_soft_start.f]
design/dpvl_pkg.sv
design/dpvl_cfg.sv
design/dpvl_err.sv
design/dpvl_mul.sv
design/dpvl_out.sv
design/dual_pi_voltage_loop_soft_start.sv
verif/tb_dual_pi_voltage_loop_soft_start.sv
